FILE: design/i2cmts_pkg.sv
// shared types and constants for the i2c master transaction sequencer
// no dependencies
package i2cmts_pkg;

    // request kinds carried by an input transaction
    typedef enum logic [1:0] {
        REQ_BEGIN   = 2'd0,
        REQ_TX_BYTE = 2'd1,
        REQ_DONE    = 2'd2,
        REQ_TICK    = 2'd3
    } req_t;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START   = 4'd1,
        PH_WADDR   = 4'd2,
        PH_REGHI   = 4'd3,
        PH_REGLO   = 4'd4,
        PH_WREQ    = 4'd5,
        PH_WDATA   = 4'd6,
        PH_RESTART = 4'd7,
        PH_RADDR   = 4'd8,
        PH_RECV    = 4'd9,
        PH_RACK    = 4'd10,
        PH_STOP    = 4'd11
    } phase_t;

    // commands to the byte engine
    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_RESTART = 3'd2,
        CMD_SEND    = 3'd3,
        CMD_RECV    = 3'd4,
        CMD_ACK     = 3'd5,
        CMD_NACK    = 3'd6,
        CMD_STOP    = 3'd7
    } cmd_t;

    // phase codes reported on timeout
    localparam logic [3:0] CODE_NONE     = 4'd0;
    localparam logic [3:0] CODE_START    = 4'd2;
    localparam logic [3:0] CODE_WADDR    = 4'd3;
    localparam logic [3:0] CODE_REGADDR  = 4'd4;
    localparam logic [3:0] CODE_POST_REG = 4'd5;
    localparam logic [3:0] CODE_WR_STOP  = 4'd6;
    localparam logic [3:0] CODE_RADDR    = 4'd6;
    localparam logic [3:0] CODE_RECV     = 4'd7;
    localparam logic [3:0] CODE_RD_STOP  = 4'd8;

    // address byte direction bits
    localparam logic [7:0] ADDR_RD_BIT  = 8'b0000_0001;
    localparam logic [7:0] ADDR_WR_MASK = 8'b1111_1110;

    // configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_DEV = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b1;
    localparam logic [6:0]  WIDE_DEV_RESET = 7'd80;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

    typedef struct packed {
        req_t        req_type;
        logic [6:0]  dev_addr;
        logic [15:0] reg_addr;
        logic [7:0]  length;
        logic        is_read;
        logic [7:0]  tx_byte;
        logic        engine_ack;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        cmd_t        bus_cmd;
        logic [7:0]  bus_byte;
        logic        need_tx_data;
        logic        rx_valid;
        logic [7:0]  rx_data;
        logic        done_res;
        logic [3:0]  error_code;
        logic        busy_res;
    } result_t;

endpackage

FILE: design/i2cmts_in_stage.sv
// input register stage of the sequencer
// depends on i2cmts_pkg
module i2cmts_in_stage
    import i2cmts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  take,
    output logic  held_valid,
    output item_t held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // stage frees up in the same cycle its transaction is consumed
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

FILE: design/i2cmts_core.sv
// sequencer state, configuration registers and one-step transition logic
// depends on i2cmts_pkg
module i2cmts_core
    import i2cmts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 step,
    input  item_t                item,
    output result_t              result
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  byte_index_reg, byte_index_next;
    logic [15:0] timeout_left_reg, timeout_left_next;
    logic [6:0]  held_dev_reg, held_dev_next;
    logic [15:0] held_reg_addr_reg, held_reg_addr_next;
    logic [7:0]  held_len_reg, held_len_next;
    logic        held_rd_reg, held_rd_next;
    logic [3:0]  code_reg, code_next;
    logic [6:0]  wide_dev_reg;
    logic [15:0] timeout_ticks_reg;

    logic [7:0]  bi_inc;
    logic        bi_inc_last;
    logic        recv_last;
    logic [15:0] tl_dec;
    logic        tl_expire;
    logic        wide_dev;
    logic [3:0]  stop_code;

    assign bi_inc      = byte_index_reg + 8'd1;
    assign bi_inc_last = (bi_inc >= held_len_reg);
    assign recv_last   = (({1'b0, byte_index_reg} + 9'd1) >= {1'b0, held_len_reg});
    assign tl_dec      = (timeout_left_reg != 16'd0) ? (timeout_left_reg - 16'd1) : 16'd0;
    assign tl_expire   = (tl_dec == 16'd0);
    assign wide_dev    = (held_dev_reg == wide_dev_reg);
    assign stop_code   = held_rd_reg ? CODE_RD_STOP : CODE_WR_STOP;

    // next state
    always_comb
    begin
        phase_next         = phase_reg;
        byte_index_next    = byte_index_reg;
        timeout_left_next  = timeout_left_reg;
        held_dev_next      = held_dev_reg;
        held_reg_addr_next = held_reg_addr_reg;
        held_len_next      = held_len_reg;
        held_rd_next       = held_rd_reg;
        code_next          = code_reg;
        unique case (item.req_type)
            REQ_BEGIN:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    held_dev_next      = item.dev_addr;
                    held_reg_addr_next = item.reg_addr;
                    held_len_next      = item.length;
                    held_rd_next       = item.is_read;
                    byte_index_next    = 8'd0;
                    timeout_left_next  = timeout_ticks_reg;
                    code_next          = CODE_START;
                    phase_next         = PH_START;
                end
            end
            REQ_TX_BYTE:
            begin
                if (phase_reg == PH_WREQ)
                begin
                    phase_next = PH_WDATA;
                end
            end
            REQ_DONE:
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        code_next  = CODE_WADDR;
                        phase_next = PH_WADDR;
                    end
                    PH_WADDR:
                    begin
                        if (item.engine_ack)
                        begin
                            code_next  = CODE_REGADDR;
                            phase_next = wide_dev ? PH_REGHI : PH_REGLO;
                        end
                    end
                    PH_REGHI:
                    begin
                        if (item.engine_ack)
                        begin
                            phase_next = PH_REGLO;
                        end
                    end
                    PH_REGLO:
                    begin
                        if (item.engine_ack)
                        begin
                            code_next = CODE_POST_REG;
                            if (held_rd_reg)
                            begin
                                phase_next = PH_RESTART;
                            end
                            else if (held_len_reg == 8'd0)
                            begin
                                code_next  = stop_code;
                                phase_next = PH_STOP;
                            end
                            else
                            begin
                                phase_next = PH_WREQ;
                            end
                        end
                    end
                    PH_WDATA:
                    begin
                        if (item.engine_ack)
                        begin
                            byte_index_next = bi_inc;
                            if (bi_inc_last)
                            begin
                                code_next  = stop_code;
                                phase_next = PH_STOP;
                            end
                            else
                            begin
                                phase_next = PH_WREQ;
                            end
                        end
                    end
                    PH_RESTART:
                    begin
                        code_next  = CODE_RADDR;
                        phase_next = PH_RADDR;
                    end
                    PH_RADDR:
                    begin
                        if (item.engine_ack)
                        begin
                            code_next = CODE_RECV;
                            if (held_len_reg == 8'd0)
                            begin
                                code_next  = stop_code;
                                phase_next = PH_STOP;
                            end
                            else
                            begin
                                phase_next = PH_RECV;
                            end
                        end
                    end
                    PH_RECV:
                    begin
                        phase_next = PH_RACK;
                    end
                    PH_RACK:
                    begin
                        byte_index_next = bi_inc;
                        if (bi_inc_last)
                        begin
                            code_next  = stop_code;
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            phase_next = PH_RECV;
                        end
                    end
                    PH_STOP:
                    begin
                        code_next  = CODE_NONE;
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            REQ_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    timeout_left_next = tl_dec;
                    if (tl_expire)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        result              = '0;
        result.bus_cmd      = CMD_NONE;
        result.busy_res     = (phase_next != PH_IDLE);
        unique case (item.req_type)
            REQ_BEGIN:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    result.bus_cmd = CMD_START;
                end
            end
            REQ_TX_BYTE:
            begin
                if (phase_reg == PH_WREQ)
                begin
                    result.bus_cmd  = CMD_SEND;
                    result.bus_byte = item.tx_byte;
                end
            end
            REQ_DONE:
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        result.bus_cmd  = CMD_SEND;
                        result.bus_byte = {held_dev_reg, 1'b0} & ADDR_WR_MASK;
                    end
                    PH_WADDR:
                    begin
                        if (item.engine_ack)
                        begin
                            result.bus_cmd  = CMD_SEND;
                            result.bus_byte = wide_dev ? held_reg_addr_reg[15:8]
                                                       : held_reg_addr_reg[7:0];
                        end
                    end
                    PH_REGHI:
                    begin
                        if (item.engine_ack)
                        begin
                            result.bus_cmd  = CMD_SEND;
                            result.bus_byte = held_reg_addr_reg[7:0];
                        end
                    end
                    PH_REGLO:
                    begin
                        if (item.engine_ack)
                        begin
                            if (held_rd_reg)
                            begin
                                result.bus_cmd = CMD_RESTART;
                            end
                            else if (held_len_reg == 8'd0)
                            begin
                                result.bus_cmd = CMD_STOP;
                            end
                            else
                            begin
                                result.need_tx_data = 1'b1;
                            end
                        end
                    end
                    PH_WDATA:
                    begin
                        if (item.engine_ack)
                        begin
                            if (bi_inc_last)
                            begin
                                result.bus_cmd = CMD_STOP;
                            end
                            else
                            begin
                                result.need_tx_data = 1'b1;
                            end
                        end
                    end
                    PH_RESTART:
                    begin
                        result.bus_cmd  = CMD_SEND;
                        result.bus_byte = {held_dev_reg, 1'b0} | ADDR_RD_BIT;
                    end
                    PH_RADDR:
                    begin
                        if (item.engine_ack)
                        begin
                            result.bus_cmd = (held_len_reg == 8'd0) ? CMD_STOP : CMD_RECV;
                        end
                    end
                    PH_RECV:
                    begin
                        result.rx_valid = 1'b1;
                        result.rx_data  = item.rx_byte;
                        result.bus_cmd  = recv_last ? CMD_NACK : CMD_ACK;
                    end
                    PH_RACK:
                    begin
                        result.bus_cmd = bi_inc_last ? CMD_STOP : CMD_RECV;
                    end
                    PH_STOP:
                    begin
                        result.done_res   = 1'b1;
                        result.error_code = CODE_NONE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            REQ_TICK:
            begin
                if ((phase_reg != PH_IDLE) && tl_expire)
                begin
                    result.done_res   = 1'b1;
                    result.error_code = code_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            byte_index_reg    <= 8'd0;
            timeout_left_reg  <= 16'd0;
            held_dev_reg      <= 7'd0;
            held_reg_addr_reg <= 16'd0;
            held_len_reg      <= 8'd0;
            held_rd_reg       <= 1'b0;
            code_reg          <= CODE_NONE;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            byte_index_reg    <= byte_index_next;
            timeout_left_reg  <= timeout_left_next;
            held_dev_reg      <= held_dev_next;
            held_reg_addr_reg <= held_reg_addr_next;
            held_len_reg      <= held_len_next;
            held_rd_reg       <= held_rd_next;
            code_reg          <= code_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_dev_reg      <= WIDE_DEV_RESET;
            timeout_ticks_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDE_DEV: wide_dev_reg      <= cfg_data[6:0];
                CFG_TIMEOUT:  timeout_ticks_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: design/i2cmts_out_stage.sv
// result register stage of the sequencer
// depends on i2cmts_pkg
module i2cmts_out_stage
    import i2cmts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_result,
    output logic    out_valid,
    input  logic    out_ready,
    output logic    free,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

FILE: design/i2c_master_transaction_sequencer_unit.sv
// top level of the i2c master register transaction sequencer
// depends on i2cmts_pkg, i2cmts_in_stage, i2cmts_core, i2cmts_out_stage
//
//  channel   handshake                  payload
//  --------  -------------------------  ------------------------------------------
//  input     in_valid / in_ready        req_type dev_addr reg_addr length is_read
//                                       tx_byte engine_ack rx_byte
//  output    out_valid / out_ready      bus_cmd bus_byte need_tx_data rx_valid
//                                       rx_data done_res error_code busy_res
//  config    cfg_we (no handshake)      cfg_index cfg_data
//
// each transaction is registered in the input register, is stepped through the
// combinational sequencer logic and lands in the result register; one transaction
// per cycle is sustained while the output is not stalled
// reset clears both stage valid bits and the sequencer state, and loads the
// configuration registers with their default values
// a stalled output holds its result while the input register still takes one more
// transaction; the step fires only when the result register is empty or draining
module i2c_master_transaction_sequencer_unit
    import i2cmts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // input transactions
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic [6:0]           dev_addr,
    input  logic [15:0]          reg_addr,
    input  logic [7:0]           length,
    input  logic                 is_read,
    input  logic [7:0]           tx_byte,
    input  logic                 engine_ack,
    input  logic [7:0]           rx_byte,

    // result transactions
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           bus_cmd,
    output logic [7:0]           bus_byte,
    output logic                 need_tx_data,
    output logic                 rx_valid,
    output logic [7:0]           rx_data,
    output logic                 done_res,
    output logic [3:0]           error_code,
    output logic                 busy_res,

    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    out_free;
    logic    step;
    result_t step_result;
    result_t out_result;

    // pack the input ports into one transaction word
    always_comb
    begin
        in_item.req_type   = req_t'(req_type);
        in_item.dev_addr   = dev_addr;
        in_item.reg_addr   = reg_addr;
        in_item.length     = length;
        in_item.is_read    = is_read;
        in_item.tx_byte    = tx_byte;
        in_item.engine_ack = engine_ack;
        in_item.rx_byte    = rx_byte;
    end

    // advance the sequencer when a transaction is held and its result has a slot
    assign step = held_valid && out_free;

    i2cmts_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (step),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    i2cmts_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (held_item),
        .result    (step_result)
    );

    i2cmts_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step),
        .load_result (step_result),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .free        (out_free),
        .out_result  (out_result)
    );

    // unpack the result register onto the output ports
    assign bus_cmd      = out_result.bus_cmd;
    assign bus_byte     = out_result.bus_byte;
    assign need_tx_data = out_result.need_tx_data;
    assign rx_valid     = out_result.rx_valid;
    assign rx_data      = out_result.rx_data;
    assign done_res     = out_result.done_res;
    assign error_code   = out_result.error_code;
    assign busy_res     = out_result.busy_res;

endmodule
